FILE: rtl/ffal_pkg.sv
// Shared widths, defaults and result codes for the first-fit free list allocator.
`timescale 1ns / 1ps

package ffal_pkg;

  // Field widths of requests and results.
  localparam int OFFSET_W = 15;
  localparam int SIZE_W   = 8;
  localparam int STATUS_W = 2;

  // Default configuration of the allocator.
  localparam int FREE_SLOTS_DEF   = 16;
  localparam int START_OFFSET_DEF = 2;

  // Result status codes.
  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_LIST_FULL = 2'd1,
    ST_NO_SPACE  = 2'd2
  } status_t;

  // Request kinds.
  typedef enum logic {
    KIND_ALLOC = 1'b0,
    KIND_FREE  = 1'b1
  } kind_t;

endpackage

FILE: rtl/ffal_ram.sv
// Generic single-write, single-read RAM with a registered read port.
`timescale 1ns / 1ps

module ffal_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/first_fit_avail_list_allocator.sv
// Top level of the first-fit free list allocator with its sequencer.
`timescale 1ns / 1ps

// The allocator hands out byte ranges of a 32 KB store. A free request pushes
// its offset and size onto a list of up to FREE_SLOTS freed blocks, or reports
// the list full and drops the request. An allocate request scans the list from
// the most recently freed block and takes the first block at least as large as
// the request, closing the gap behind it; if none fits, it appends at the end
// offset, or reports out of space when the end would pass the top of the store.
// The list lives in one RAM with a registered read, and one sequencer walks it,
// so the block takes one request at a time. A free writes the list in S_FREE.
// An allocate reads and checks each list entry examined (S_SCAN_RD, S_SCAN_CHK),
// moves each entry after a hit down (S_SHIFT_RD, S_SHIFT_WR), and passes through
// S_APPEND when it falls through to the end of the store; all end in S_RESULT.
// Each result sits in an output register, so the next request can be taken
// while the previous result waits for m_tready.
module first_fit_avail_list_allocator
  import ffal_pkg::*;
#(
  parameter int FREE_SLOTS   = FREE_SLOTS_DEF,
  parameter int START_OFFSET = START_OFFSET_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // Request stream.
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // [7:0] block_size, [22:8] block_offset, [23] zero
  input  logic [0:0]  s_tuser,   // [0] kind
  // Result stream.
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // [14:0] granted_offset, [15] zero
  output logic [2:0]  m_tuser    // [0] reused, [2:1] status
);

  localparam int IDX_W = $clog2(FREE_SLOTS);
  localparam int CNT_W = $clog2(FREE_SLOTS + 1);
  localparam int ENT_W = OFFSET_W + SIZE_W;

  typedef enum logic [7:0] {
    S_IDLE     = 8'b0000_0001,
    S_FREE     = 8'b0000_0010,
    S_SCAN_RD  = 8'b0000_0100,
    S_SCAN_CHK = 8'b0000_1000,
    S_SHIFT_RD = 8'b0001_0000,
    S_SHIFT_WR = 8'b0010_0000,
    S_APPEND   = 8'b0100_0000,
    S_RESULT   = 8'b1000_0000
  } state_t;

  state_t state, state_next;

  // Control state.
  logic [CNT_W-1:0]    free_count;
  logic [OFFSET_W-1:0] end_offset;
  logic [IDX_W-1:0]    idx;

  // Latched request and pending result.
  kind_t               req_kind;
  logic [SIZE_W-1:0]   req_size;
  logic [OFFSET_W-1:0] req_offset;
  logic [OFFSET_W-1:0] res_offset;
  logic                res_reused;
  status_t             res_status;

  // RAM ports.
  logic                ram_we;
  logic [IDX_W-1:0]    ram_waddr;
  logic [ENT_W-1:0]    ram_wdata;
  logic [IDX_W-1:0]    ram_raddr;
  logic [ENT_W-1:0]    ram_rdata;
  logic [OFFSET_W-1:0] rd_offset;
  logic [SIZE_W-1:0]   rd_size;

  // Shared datapath pieces.
  logic                list_full;
  logic [CNT_W-1:0]    idx_ext;
  logic [OFFSET_W:0]   end_sum;
  logic                out_free;

  assign rd_offset = ram_rdata[ENT_W-1:SIZE_W];
  assign rd_size   = ram_rdata[SIZE_W-1:0];
  assign list_full = (free_count == CNT_W'(FREE_SLOTS));
  assign idx_ext   = CNT_W'(idx);
  assign end_sum   = {1'b0, end_offset} + (OFFSET_W+1)'(req_size);
  assign out_free  = !m_tvalid || m_tready;
  assign s_tready  = (state == S_IDLE);

  ffal_ram #(
    .WIDTH (ENT_W),
    .DEPTH (FREE_SLOTS)
  ) u_list (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // RAM access: push on free, move entries down while closing a gap.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = idx;
    ram_wdata = ram_rdata;
    ram_raddr = idx;
    unique case (state)
      S_FREE: begin
        ram_we    = !list_full;
        ram_waddr = free_count[IDX_W-1:0];
        ram_wdata = {req_offset, req_size};
      end
      S_SHIFT_RD: begin
        ram_raddr = IDX_W'(idx_ext + CNT_W'(1));
      end
      S_SHIFT_WR: begin
        ram_we = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // Next-state logic of the sequencer.
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          if (s_tuser[0] == KIND_FREE) begin
            state_next = S_FREE;
          end else if (free_count == '0) begin
            state_next = S_APPEND;
          end else begin
            state_next = S_SCAN_RD;
          end
        end
      end
      S_FREE:    state_next = S_RESULT;
      S_SCAN_RD: state_next = S_SCAN_CHK;
      S_SCAN_CHK: begin
        if (rd_size >= req_size) begin
          if (idx_ext + CNT_W'(1) < free_count) begin
            state_next = S_SHIFT_RD;
          end else begin
            state_next = S_RESULT;
          end
        end else if (idx == '0) begin
          state_next = S_APPEND;
        end else begin
          state_next = S_SCAN_RD;
        end
      end
      S_SHIFT_RD: state_next = S_SHIFT_WR;
      S_SHIFT_WR: begin
        if (idx_ext + CNT_W'(2) < free_count) begin
          state_next = S_SHIFT_RD;
        end else begin
          state_next = S_RESULT;
        end
      end
      S_APPEND: state_next = S_RESULT;
      S_RESULT: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Sequencer registers, list count and end of store.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      free_count <= '0;
      end_offset <= OFFSET_W'(START_OFFSET);
    end else begin
      state <= state_next;
      if (state == S_FREE && !list_full) begin
        free_count <= free_count + CNT_W'(1);
      end
      if ((state == S_SCAN_CHK && rd_size >= req_size &&
           !(idx_ext + CNT_W'(1) < free_count)) ||
          (state == S_SHIFT_WR && !(idx_ext + CNT_W'(2) < free_count))) begin
        free_count <= free_count - CNT_W'(1);
      end
      if (state == S_APPEND && !end_sum[OFFSET_W]) begin
        end_offset <= end_sum[OFFSET_W-1:0];
      end
    end
  end

  // Request latch, scan index and pending result.
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        req_kind   <= kind_t'(s_tuser[0]);
        req_size   <= s_tdata[SIZE_W-1:0];
        req_offset <= s_tdata[SIZE_W+OFFSET_W-1:SIZE_W];
        idx        <= IDX_W'(free_count - CNT_W'(1));
      end
      S_FREE: begin
        res_offset <= '0;
        res_reused <= 1'b0;
        res_status <= list_full ? ST_LIST_FULL : ST_OK;
      end
      S_SCAN_CHK: begin
        if (rd_size >= req_size) begin
          res_offset <= rd_offset;
          res_reused <= 1'b1;
          res_status <= ST_OK;
        end else if (idx != '0) begin
          idx <= idx - IDX_W'(1);
        end
      end
      S_SHIFT_WR: begin
        idx <= IDX_W'(idx_ext + CNT_W'(1));
      end
      S_APPEND: begin
        res_reused <= 1'b0;
        if (end_sum[OFFSET_W]) begin
          res_offset <= '0;
          res_status <= ST_NO_SPACE;
        end else begin
          res_offset <= end_offset;
          res_status <= ST_OK;
        end
      end
      default: begin
      end
    endcase
  end

  // Output register: loaded when the sequencer finishes and the slot is free.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == S_RESULT && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_RESULT && out_free) begin
      m_tdata <= {1'b0, res_offset};
      m_tuser <= {res_status, res_reused};
    end
  end

`ifndef ASSERT_OFF
  // The list never holds more entries than it has slots.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    free_count <= CNT_W'(FREE_SLOTS))
    else $error("free list count exceeds its capacity");

  // The list count moves by at most one per cycle.
  a_count_step: assert property (@(posedge clk) disable iff (rst)
    1'b1 |=> (free_count == $past(free_count) ||
              free_count == $past(free_count) + CNT_W'(1) ||
              free_count == $past(free_count) - CNT_W'(1)))
    else $error("free list count jumped");

  // The end of the store never moves backward.
  a_end_mono: assert property (@(posedge clk) disable iff (rst)
    1'b1 |=> end_offset >= $past(end_offset))
    else $error("end offset moved backward");

  // A block taken from the list is always a successful grant.
  a_reuse_ok: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser[0]) |-> (m_tuser[2:1] == ST_OK))
    else $error("reused result carries an error status");

  // A free request never writes the list once it is full.
  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    (state == S_FREE && req_kind == KIND_FREE && list_full) |-> !ram_we)
    else $error("write into a full free list");
`endif

endmodule

FILE: bench/tb_first_fit_avail_list_allocator.sv
// Self-checking testbench for the first-fit free list allocator.
`timescale 1ns / 1ps

module tb_first_fit_avail_list_allocator;
  import ffal_pkg::*;

  localparam int STORE_TOP   = (1 << OFFSET_W) - 1;
  localparam int CYCLE_LIMIT = 600000;
  localparam int RANDOM_REQS = 1550;
  localparam int SETTLE_CYC  = 40;

  // One request as the driver sends it; hold_for_drain makes the driver wait
  // until every result already owed has come back.
  typedef struct packed {
    logic                hold_for_drain;
    kind_t               kind;
    logic [SIZE_W-1:0]   size;
    logic [OFFSET_W-1:0] offset;
  } alloc_req_t;

  typedef struct packed {
    logic [OFFSET_W-1:0] offset;
    logic                reused;
    status_t             status;
  } grant_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [23:0] s_tdata = '0;   // [7:0] block_size, [22:8] block_offset, [23] zero
  logic [0:0]  s_tuser = '0;   // [0] kind
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;        // [14:0] granted_offset, [15] zero
  logic [2:0]  m_tuser;        // [0] reused, [2:1] status

  alloc_req_t pending_reqs[$];
  grant_t     expected_grants[$];

  // Shadow copy of the allocator state.
  logic [OFFSET_W-1:0] shadow_offs[FREE_SLOTS_DEF];
  logic [SIZE_W-1:0]   shadow_sizes[FREE_SLOTS_DEF];
  int                  shadow_count = 0;
  int                  shadow_end = START_OFFSET_DEF;

  int errors = 0;
  int reqs_accepted = 0;
  int grants_seen = 0;
  int cycle_count = 0;

  first_fit_avail_list_allocator i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("%0t ns: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
    errors++;
  endtask

  // Applies one request to the shadow state and returns the grant it causes.
  function automatic grant_t predict_grant(input alloc_req_t req);
    grant_t g;
    int     n;
    int     hit_idx;
    g = '{offset: '0, reused: 1'b0, status: ST_OK};
    hit_idx = -1;
    if (req.kind == KIND_FREE) begin
      if (shadow_count >= FREE_SLOTS_DEF) begin
        g.status = ST_LIST_FULL;
      end else begin
        shadow_offs[shadow_count]  = req.offset;
        shadow_sizes[shadow_count] = req.size;
        shadow_count++;
      end
      return g;
    end
    // Scan from the most recently freed block down to the oldest.
    for (n = shadow_count - 1; n >= 0 && hit_idx < 0; n--) begin
      if (shadow_sizes[n] >= req.size) hit_idx = n;
    end
    if (hit_idx >= 0) begin
      g.offset = shadow_offs[hit_idx];
      g.reused = 1'b1;
      for (n = hit_idx; n < shadow_count - 1; n++) begin
        shadow_offs[n]  = shadow_offs[n + 1];
        shadow_sizes[n] = shadow_sizes[n + 1];
      end
      shadow_count--;
    end else if (shadow_end + int'(req.size) > STORE_TOP) begin
      g.status = ST_NO_SPACE;
    end else begin
      g.offset   = shadow_end[OFFSET_W-1:0];
      shadow_end = shadow_end + int'(req.size);
    end
    return g;
  endfunction

  // Idle draw: some stretches run with no idling at all.
  function automatic int draw_idle(input int progress);
    if ((progress / 150) % 5 == 2) return 0;
    return $urandom_range(0, 10);
  endfunction

  task automatic add_req(input kind_t kind, input logic [SIZE_W-1:0] size,
                         input logic [OFFSET_W-1:0] offset, input logic hold);
    alloc_req_t r;
    r.hold_for_drain = hold;
    r.kind           = kind;
    r.size           = size;
    r.offset         = offset;
    pending_reqs = {pending_reqs, r};
  endtask

  // Request driver.
  int         send_gap = 0;
  alloc_req_t cur_req;
  always @(posedge clk) begin
    logic holding;
    logic next_valid;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      holding = s_tvalid && !s_tready;
      if (s_tvalid && s_tready) begin
        expected_grants = {expected_grants, predict_grant(cur_req)};
        reqs_accepted++;
        send_gap = draw_idle(reqs_accepted);
      end
      next_valid = holding;
      if (!holding) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (pending_reqs.size() != 0 &&
                     !(pending_reqs[0].hold_for_drain && grants_seen != reqs_accepted)) begin
          cur_req = pending_reqs.pop_front();
          s_tdata <= {1'b0, cur_req.offset, cur_req.size};
          s_tuser <= cur_req.kind;
          next_valid = 1'b1;
        end
      end
      s_tvalid <= next_valid;
    end
  end

  // Result monitor and back-pressure.
  int stall_left = 0;
  always @(posedge clk) begin
    grant_t want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (expected_grants.size() == 0) begin
          report_mismatch("result with nothing expected", int'(m_tdata), 0);
        end else begin
          want = expected_grants.pop_front();
          if (m_tdata[OFFSET_W-1:0] != want.offset)
            report_mismatch("granted_offset", int'(m_tdata[OFFSET_W-1:0]), int'(want.offset));
          if (m_tuser[0] != want.reused)
            report_mismatch("reused", int'(m_tuser[0]), int'(want.reused));
          if (m_tuser[2:1] != want.status)
            report_mismatch("status", int'(m_tuser[2:1]), int'(want.status));
        end
        grants_seen <= grants_seen + 1;
        stall_left = draw_idle(grants_seen);
      end
      if (stall_left > 0) begin
        stall_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb_first_fit_avail_list_allocator: FAIL");
      $finish;
    end
  end

  // Stimulus and end of run.
  initial begin
    int               i;
    int               k;
    int               chunk;
    int               made;
    logic [SIZE_W-1:0] freed_sizes[8];
    logic [SIZE_W-1:0] sz;

    // Directed part: zero-size allocate on an empty list, largest allocate,
    // frees at the extremes, zero-size allocate taking the head, then a full list.
    add_req(KIND_ALLOC, 8'd0,   15'd0,     1'b0);
    add_req(KIND_ALLOC, 8'd255, 15'h7fff,  1'b0);
    add_req(KIND_ALLOC, 8'd0,   15'd0,     1'b0);
    add_req(KIND_FREE,  8'd0,   15'd0,     1'b0);
    add_req(KIND_FREE,  8'd255, 15'h7fff,  1'b0);
    add_req(KIND_ALLOC, 8'd0,   15'd0,     1'b0);
    add_req(KIND_ALLOC, 8'd1,   15'h7fff,  1'b0);
    add_req(KIND_ALLOC, 8'd0,   15'd0,     1'b0);
    for (i = 0; i < FREE_SLOTS_DEF + 1; i++) begin
      add_req(KIND_FREE, (i % 2) ? 8'd255 : 8'(i * 13),
              (i % 2) ? 15'h7fff - 15'(i) : 15'(i * 97), 1'b0);
    end

    // Random part, built from chunks of different shapes.
    made = 0;
    while (made < RANDOM_REQS) begin
      chunk = $urandom_range(0, 9);
      if (chunk < 5) begin
        // Free a few blocks, then allocate sizes that mostly fit one of them.
        k = $urandom_range(1, 6);
        for (i = 0; i < k; i++) begin
          freed_sizes[i] = 8'($urandom);
          add_req(KIND_FREE, freed_sizes[i], 15'($urandom), made == 0);
          made++;
        end
        for (i = 0; i < k; i++) begin
          if ($urandom_range(0, 3) == 0) sz = 8'($urandom);
          else sz = 8'($urandom_range(0, freed_sizes[$urandom_range(0, k - 1)]));
          add_req(KIND_ALLOC, sz, 15'($urandom), $urandom_range(0, 99) == 0);
          made++;
        end
      end else if (chunk < 7) begin
        // Large allocates that push the end offset toward the top of the store.
        k = $urandom_range(4, 8);
        for (i = 0; i < k; i++) begin
          add_req(KIND_ALLOC, 8'($urandom_range(128, 255)), 15'($urandom), 1'b0);
          made++;
        end
      end else if (chunk == 7) begin
        // A run of frees that can be long enough to fill the list.
        k = $urandom_range(12, 20);
        for (i = 0; i < k; i++) begin
          add_req(KIND_FREE, 8'($urandom), 15'($urandom), 1'b0);
          made++;
        end
      end else begin
        // Noise.
        k = $urandom_range(1, 8);
        for (i = 0; i < k; i++) begin
          add_req($urandom_range(0, 1) ? KIND_FREE : KIND_ALLOC, 8'($urandom),
                  15'($urandom), $urandom_range(0, 99) == 0);
          made++;
        end
      end
    end

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    while (pending_reqs.size() != 0 || s_tvalid || expected_grants.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
    if (expected_grants.size() != 0)
      report_mismatch("results still owed at end", 0, expected_grants.size());
    if (errors == 0) begin
      $display("tb_first_fit_avail_list_allocator: PASS");
    end else begin
      $display("tb_first_fit_avail_list_allocator: FAIL");
    end
    $finish;
  end

endmodule
